### rtl/core/srv_pkg.sv
package srv_pkg;

  localparam int unsigned OffW = 10;

  localparam logic [OffW-1:0] RecLen     = 10'd512;
  localparam logic [OffW-1:0] LastOff    = 10'd511;
  localparam logic [OffW-1:0] OffSat     = 10'd513;
  localparam logic [OffW-1:0] ResHeadAt  = 10'h008;
  localparam logic [OffW-1:0] SizeAt     = 10'h00c;
  localparam logic [OffW-1:0] IdAt       = 10'h010;
  localparam logic [OffW-1:0] SeedAt     = 10'h030;
  localparam logic [OffW-1:0] KeyAt      = 10'h070;
  localparam logic [OffW-1:0] TextAt     = 10'h0b4;
  localparam logic [OffW-1:0] TailResAt  = 10'h1b4;
  localparam logic [OffW-1:0] CrcAt      = 10'h1fc;

  localparam logic [31:0] CrcPoly    = 32'hedb88320;
  localparam logic [31:0] CrcInit    = 32'hffffffff;
  localparam logic [7:0]  PrintMin   = 8'h20;
  localparam logic [7:0]  PrintMax   = 8'h7e;
  localparam logic [7:0]  NewLine    = 8'h0a;
  localparam logic [5:0]  KeyHeadLen = 6'd19;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StLength   = 4'd1,
    StMagic    = 4'd2,
    StSize     = 4'd3,
    StCrc      = 4'd4,
    StReserved = 4'd5,
    StId       = 4'd6,
    StSeed     = 4'd7,
    StKey      = 4'd8,
    StText     = 4'd9
  } status_e;

  typedef struct packed {
    logic magic_bad;
    logic size_bad;
    logic res_bad;
    logic id_seen;
    logic seed_seen;
    logic key_bad;
    logic tail_seen;
    logic text_bad;
    logic nul_seen;
    logic prev_nl;
  } flags_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = "F";
      3'd1: r = "P";
      3'd2: r = "L";
      3'd3: r = "S";
      3'd4: r = "E";
      3'd5: r = "S";
      3'd6: r = "S";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] size_byte(input logic [1:0] i);
    return (i == 2'd1) ? 8'h02 : 8'h00;
  endfunction

  function automatic logic [7:0] key_head_byte(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd3:  r = 8'h0b;
      5'd4:  r = "s";
      5'd5:  r = "s";
      5'd6:  r = "h";
      5'd7:  r = "-";
      5'd8:  r = "e";
      5'd9:  r = "d";
      5'd10: r = "2";
      5'd11: r = "5";
      5'd12: r = "5";
      5'd13: r = "1";
      5'd14: r = "9";
      5'd18: r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // bit 6 set marks a character outside the base64 alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    if (ch >= "A" && ch <= "Z") begin
      r = 7'(ch - 8'd65);
    end else if (ch >= "a" && ch <= "z") begin
      r = 7'(ch - 8'd71);
    end else if (ch >= "0" && ch <= "9") begin
      r = 7'(ch + 8'd4);
    end else if (ch == "+") begin
      r = 7'd62;
    end else if (ch == "/") begin
      r = 7'd63;
    end else begin
      r = 7'd64;
    end
    return r;
  endfunction

endpackage

### rtl/core/session_record_validator_unit.sv
// A result is registered: the last byte passes the input register, then the result register.
// Throughput: one record byte per cycle; only the output register can stall the input.
// Reset: rst_ni clears all record state and the valid flags of the input stage and the
// output register; the unit also returns to its reset state after every last byte.
module session_record_validator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [3:0] status, [35:4] computed_crc, [39:36] zero
);
  import srv_pkg::*;

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            accept, go;

  logic [OffW-1:0] off_q, off_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     stored_q, stored_d;
  flags_t          flg_q, flg_d;
  logic [5:0]      hold_q, hold_d;
  logic [1:0]      phase_q, phase_d;
  logic [5:0]      idx_q, idx_d;

  logic            m_valid_q, m_valid_d;
  status_e         m_status_q, status_d;
  logic [31:0]     m_crc_q, crc_out_d;

  logic [6:0]      sx;
  logic [5:0]      sv;
  logic [7:0]      kb;
  logic            kb_valid;

  assign go            = in_valid_q && (!in_last_q || !m_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept ? 1'b1 : (go ? 1'b0 : in_valid_q);
  assign m_valid_d     = (go && in_last_q) ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_comb begin
    off_d     = off_q;
    crc_d     = crc_q;
    stored_d  = stored_q;
    flg_d     = flg_q;
    hold_d    = hold_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    sx        = sextet_of(in_byte_q);
    sv        = sx[6] ? 6'd0 : sx[5:0];
    kb        = 8'd0;
    kb_valid  = 1'b0;
    status_d  = StOk;
    crc_out_d = 32'd0;

    if (off_q < RecLen) begin
      if (off_q < CrcAt) begin
        crc_d = crc_byte(crc_q, in_byte_q);
      end else begin
        stored_d = stored_q | ({24'd0, in_byte_q} << {off_q[1:0], 3'b000});
      end

      priority if (off_q < ResHeadAt) begin
        if (in_byte_q != magic_byte(off_q[2:0])) flg_d.magic_bad = 1'b1;
      end else if (off_q < SizeAt) begin
        if (in_byte_q != 8'd0) flg_d.res_bad = 1'b1;
      end else if (off_q < IdAt) begin
        if (in_byte_q != size_byte(off_q[1:0])) flg_d.size_bad = 1'b1;
      end else if (off_q < SeedAt) begin
        if (in_byte_q != 8'd0) flg_d.id_seen = 1'b1;
      end else if (off_q < KeyAt) begin
        if (in_byte_q != 8'd0) flg_d.seed_seen = 1'b1;
      end else if (off_q < TextAt) begin
        // base64 character: emit a byte on every phase but the first
        if (sx[6]) flg_d.key_bad = 1'b1;
        unique case (phase_q)
          2'd0: begin
            hold_d = sv;
          end
          2'd1: begin
            kb       = {hold_q, sv[5:4]};
            kb_valid = 1'b1;
            hold_d   = {2'd0, sv[3:0]};
          end
          2'd2: begin
            kb       = {hold_q[3:0], sv[5:2]};
            kb_valid = 1'b1;
            hold_d   = {4'd0, sv[1:0]};
          end
          default: begin
            kb       = {hold_q[1:0], sv};
            kb_valid = 1'b1;
            hold_d   = 6'd0;
          end
        endcase
        phase_d = phase_q + 2'd1;
        if (kb_valid) begin
          if (idx_q < KeyHeadLen) begin
            if (kb != key_head_byte(idx_q[4:0])) flg_d.key_bad = 1'b1;
          end else if (kb != 8'd0) begin
            flg_d.tail_seen = 1'b1;
          end
          idx_d = idx_q + 6'd1;
        end
      end else if (off_q < TailResAt) begin
        if (flg_q.nul_seen) begin
          if (in_byte_q != 8'd0) flg_d.text_bad = 1'b1;
        end else if (in_byte_q == 8'd0) begin
          flg_d.nul_seen = 1'b1;
          if (off_q == TextAt || !flg_q.prev_nl) flg_d.text_bad = 1'b1;
        end else begin
          if (in_byte_q != NewLine && (in_byte_q < PrintMin || in_byte_q > PrintMax)) begin
            flg_d.text_bad = 1'b1;
          end
          flg_d.prev_nl = (in_byte_q == NewLine);
        end
      end else if (off_q < CrcAt) begin
        if (in_byte_q != 8'd0) flg_d.res_bad = 1'b1;
      end else begin
        // stored CRC word, handled above
      end
    end

    if (in_last_q) begin
      crc_out_d = crc_d ^ CrcInit;
      priority if (off_q != LastOff)                 status_d = StLength;
      else if (flg_d.magic_bad)                      status_d = StMagic;
      else if (flg_d.size_bad)                       status_d = StSize;
      else if (stored_d != crc_out_d)                status_d = StCrc;
      else if (flg_d.res_bad)                        status_d = StReserved;
      else if (!flg_d.id_seen)                       status_d = StId;
      else if (!flg_d.seed_seen)                     status_d = StSeed;
      else if (flg_d.key_bad || !flg_d.tail_seen)    status_d = StKey;
      else if (flg_d.text_bad || !flg_d.nul_seen)    status_d = StText;
      else                                           status_d = StOk;
      // start over for the next record
      off_d    = '0;
      crc_d    = CrcInit;
      stored_d = 32'd0;
      flg_d    = '0;
      hold_d   = 6'd0;
      phase_d  = 2'd0;
      idx_d    = 6'd0;
    end else if (off_q < OffSat) begin
      off_d = off_q + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      off_q      <= '0;
      crc_q      <= CrcInit;
      stored_q   <= 32'd0;
      flg_q      <= '0;
      hold_q     <= 6'd0;
      phase_q    <= 2'd0;
      idx_q      <= 6'd0;
    end else begin
      in_valid_q <= in_valid_d;
      m_valid_q  <= m_valid_d;
      if (go) begin
        off_q    <= off_d;
        crc_q    <= crc_d;
        stored_q <= stored_d;
        flg_q    <= flg_d;
        hold_q   <= hold_d;
        phase_q  <= phase_d;
        idx_q    <= idx_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (go && in_last_q) begin
      m_status_q <= status_d;
      m_crc_q    <= crc_out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_crc_q, m_status_q};

endmodule

### bench/record_board_pkg.sv
`timescale 1ns / 100ps

package record_board_pkg;

  import srv_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [31:0] crc;
  } verdict_t;

  function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // 64 marks a character outside the base64 alphabet
  function automatic int b64_value(input logic [7:0] ch);
    int c;
    c = int'(ch);
    if (c >= 65 && c <= 90) return c - 65;
    if (c >= 97 && c <= 122) return c - 97 + 26;
    if (c >= 48 && c <= 57) return c - 48 + 52;
    if (c == 43) return 62;
    if (c == 47) return 63;
    return 64;
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'(65 + v);
    if (v < 52) return 8'(97 + v - 26);
    if (v < 62) return 8'(48 + v - 52);
    if (v == 62) return 8'd43;
    return 8'd47;
  endfunction

  function automatic logic [7:0] magic_char(input int i);
    string tag;
    tag = "FPLSESS";
    return (i < 7) ? tag[i] : 8'h00;
  endfunction

  // 00 00 00 0b "ssh-ed25519" 00 00 00 20
  function automatic logic [7:0] key_prefix(input int i);
    string tag;
    tag = "ssh-ed25519";
    if (i == 3) return 8'h0b;
    if (i >= 4 && i < 15) return tag[i-4];
    if (i == 18) return 8'h20;
    return 8'h00;
  endfunction

  class verdict_board;
    verdict_t    verdict_q[$];
    int          errors;
    int unsigned rec_off;
    logic [31:0] crc_acc;
    logic [31:0] crc_stored;
    bit          magic_bad, size_bad, res_bad, id_seen, seed_seen;
    bit          key_bad, tail_seen, text_bad, nul_seen, prev_nl;
    logic [5:0]  b64_hold;
    logic [1:0]  b64_phase;
    logic [5:0]  key_idx;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      rec_off    = 0;
      crc_acc    = CrcInit;
      crc_stored = '0;
      magic_bad  = 0;
      size_bad   = 0;
      res_bad    = 0;
      id_seen    = 0;
      seed_seen  = 0;
      key_bad    = 0;
      tail_seen  = 0;
      text_bad   = 0;
      nul_seen   = 0;
      prev_nl    = 0;
      b64_hold   = '0;
      b64_phase  = '0;
      key_idx    = '0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void key_emit(input logic [7:0] b);
      if (key_idx < KeyHeadLen) begin
        if (b != key_prefix(int'(key_idx))) key_bad = 1;
      end else if (b != 8'h00) begin
        tail_seen = 1;
      end
      key_idx = key_idx + 6'd1;
    endfunction

    function void key_char(input logic [7:0] ch);
      int v;
      v = b64_value(ch);
      if (v == 64) begin
        key_bad = 1;
        v = 0;
      end
      case (b64_phase)
        2'd0: b64_hold = 6'(v);
        2'd1: begin
          key_emit(8'((int'(b64_hold) << 2) | (v >> 4)));
          b64_hold = 6'(v & 15);
        end
        2'd2: begin
          key_emit(8'((int'(b64_hold) << 4) | (v >> 2)));
          b64_hold = 6'(v & 3);
        end
        default: begin
          key_emit(8'((int'(b64_hold) << 6) | v));
          b64_hold = '0;
        end
      endcase
      b64_phase = b64_phase + 2'd1;
    endfunction

    function void text_char(input int pos, input logic [7:0] b);
      if (nul_seen) begin
        if (b != 8'h00) text_bad = 1;
        return;
      end
      if (b == 8'h00) begin
        nul_seen = 1;
        if (pos == 0 || !prev_nl) text_bad = 1;
        return;
      end
      if (b != NewLine && (b < PrintMin || b > PrintMax)) text_bad = 1;
      prev_nl = (b == NewLine);
    endfunction

    function void take_byte(input int off, input logic [7:0] b);
      if (off < int'(CrcAt)) begin
        crc_acc = crc_update(crc_acc, b);
      end else begin
        crc_stored |= {24'd0, b} << (8 * (off - int'(CrcAt)));
      end
      if (off < int'(ResHeadAt)) begin
        if (b != magic_char(off)) magic_bad = 1;
      end else if (off < int'(SizeAt)) begin
        if (b != 8'h00) res_bad = 1;
      end else if (off < int'(IdAt)) begin
        if (b != ((off == int'(SizeAt) + 1) ? 8'h02 : 8'h00)) size_bad = 1;
      end else if (off < int'(SeedAt)) begin
        if (b != 8'h00) id_seen = 1;
      end else if (off < int'(KeyAt)) begin
        if (b != 8'h00) seed_seen = 1;
      end else if (off < int'(TextAt)) begin
        key_char(b);
      end else if (off < int'(TailResAt)) begin
        text_char(off - int'(TextAt), b);
      end else if (off < int'(CrcAt)) begin
        if (b != 8'h00) res_bad = 1;
      end
    endfunction

    function status_e first_failure(input logic [31:0] crc_now);
      if (rec_off != int'(LastOff)) return StLength;
      if (magic_bad) return StMagic;
      if (size_bad) return StSize;
      if (crc_stored != crc_now) return StCrc;
      if (res_bad) return StReserved;
      if (!id_seen) return StId;
      if (!seed_seen) return StSeed;
      if (key_bad || !tail_seen) return StKey;
      if (text_bad || !nul_seen) return StText;
      return StOk;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      verdict_t v;
      if (rec_off < int'(RecLen)) take_byte(int'(rec_off), b);
      if (!last) begin
        if (rec_off < int'(OffSat)) rec_off++;
      end else begin
        v.crc    = ~crc_acc;
        v.status = first_failure(v.crc);
        verdict_q.push_back(v);
        clear();
      end
    endfunction

    task check_verdict(input logic [39:0] word);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result status %0d crc %08h", word[3:0], word[35:4]));
        return;
      end
      want = verdict_q.pop_front();
      if (word[3:0] != want.status) begin
        report($sformatf("status %0d, want %0d", word[3:0], want.status));
      end
      if (word[35:4] != want.crc) begin
        report($sformatf("crc %08h, want %08h", word[35:4], want.crc));
      end
      if (word[39:36] != 4'd0) begin
        report($sformatf("pad bits %h, want 0", word[39:36]));
      end
    endtask
  endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import srv_pkg::*;
  import record_board_pkg::*;

  typedef enum int {
    FltNone, FltMagic, FltSize, FltCrc, FltResHead, FltResTail, FltIdZero, FltSeedZero,
    FltKeyChar, FltKeyHead, FltTailZero, FltTextEmpty, FltTextNoNul, FltTextNoNl,
    FltTextCtrl, FltTextPad, FltShort, FltLong, FltCount
  } fault_e;

  localparam logic [10:0] RxPattern = 11'b10110011101;
  localparam int          ItemTarget = 1400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  verdict_board sb = new();
  logic [7:0]   rec_buf[$];
  int           burst_left = 0;
  bit           steady = 0;
  int unsigned  rx_tick = 0;
  int           rx_mode = 0;
  int           sent = 0;

  session_record_validator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // receiver: periodically pick one of four stall styles at random
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 300 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= RxPattern[rx_tick % 11];
      default: m_axis_tready <= (rx_tick % 29) > 21;
    endcase
  end

  function automatic logic [7:0] pick_text_char();
    return ($urandom_range(0, 15) == 0) ? NewLine : 8'($urandom_range(32, 126));
  endfunction

  task automatic fill_field(input int at, input int len, input bit zero);
    if (zero) return;
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < len; i++) rec_buf[at+i] = 8'($urandom);
    end else begin
      rec_buf[at+$urandom_range(0, len-1)] = 8'($urandom_range(1, 255));
    end
  endtask

  task automatic build_noise(input int len);
    rec_buf.delete();
    repeat (len) rec_buf.push_back(8'($urandom));
  endtask

  task automatic build_record(input fault_e fa, input fault_e fb);
    logic [7:0]  key_raw [51];
    logic [23:0] grp;
    logic [31:0] crc;
    logic [31:0] want;
    logic [7:0]  c;
    int          nul_at;
    int          cut;
    want = (32'd1 << fa) | (32'd1 << fb);
    rec_buf.delete();
    repeat (512) rec_buf.push_back(8'h00);
    for (int i = 0; i < 8; i++) rec_buf[i] = magic_char(i);
    rec_buf[SizeAt+1] = 8'h02;
    fill_field(IdAt, 32, want[FltIdZero]);
    fill_field(SeedAt, 64, want[FltSeedZero]);

    for (int i = 0; i < 51; i++) begin
      key_raw[i] = (i < 19) ? key_prefix(i) : ($urandom_range(0, 1) ? 8'($urandom) : 8'h00);
    end
    if (want[FltTailZero]) begin
      for (int i = 19; i < 51; i++) key_raw[i] = 8'h00;
    end else begin
      key_raw[$urandom_range(19, 50)] = 8'($urandom_range(1, 255));
    end
    if (want[FltKeyHead]) key_raw[$urandom_range(0, 18)] ^= 8'(1 << $urandom_range(0, 7));
    for (int g = 0; g < 17; g++) begin
      grp = {key_raw[3*g], key_raw[3*g+1], key_raw[3*g+2]};
      for (int j = 0; j < 4; j++) rec_buf[KeyAt+4*g+j] = b64_char(int'(grp >> (18 - 6*j)) & 63);
    end
    if (want[FltKeyChar]) begin
      do c = 8'($urandom); while (b64_value(c) != 64);
      rec_buf[KeyAt+$urandom_range(0, 67)] = c;
    end

    if (want[FltTextNoNul]) begin
      nul_at = 256;
      for (int i = 0; i < 256; i++) rec_buf[TextAt+i] = pick_text_char();
    end else begin
      case ($urandom_range(0, 7))
        0: nul_at = 1;
        1: nul_at = 255;
        default: nul_at = $urandom_range(2, 120);
      endcase
      for (int i = 0; i < nul_at - 1; i++) rec_buf[TextAt+i] = pick_text_char();
      rec_buf[TextAt+nul_at-1] = NewLine;
    end
    if (want[FltTextEmpty]) begin
      for (int i = 0; i < 256; i++) rec_buf[TextAt+i] = 8'h00;
    end
    if (want[FltTextNoNl]) rec_buf[TextAt+nul_at-1] = 8'($urandom_range(33, 126));
    if (want[FltTextCtrl]) begin
      do c = 8'($urandom); while (c == NewLine || c == 8'h00 || (c >= PrintMin && c <= PrintMax));
      rec_buf[TextAt+$urandom_range(0, nul_at-1)] = c;
    end
    if (want[FltTextPad]) begin
      if (nul_at < 255) begin
        rec_buf[TextAt+$urandom_range(nul_at+1, 255)] = 8'($urandom_range(1, 255));
      end else if (nul_at == 255) begin
        rec_buf[TextAt+255] = 8'h78;
      end
    end

    if (want[FltMagic]) rec_buf[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    if (want[FltSize]) rec_buf[SizeAt+$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    if (want[FltResHead]) rec_buf[ResHeadAt+$urandom_range(0, 3)] = 8'($urandom_range(1, 255));
    if (want[FltResTail]) begin
      rec_buf[$urandom_range(TailResAt, CrcAt-1)] = 8'($urandom_range(1, 255));
    end

    crc = CrcInit;
    for (int i = 0; i < CrcAt; i++) crc = crc_update(crc, rec_buf[i]);
    crc = ~crc;
    for (int j = 0; j < 4; j++) rec_buf[CrcAt+j] = crc[8*j +: 8];
    if (want[FltCrc]) rec_buf[CrcAt+$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));

    if (want[FltShort]) begin
      cut = ($urandom_range(0, 3) == 0) ? 511 : $urandom_range(1, 510);
      while (rec_buf.size() > cut) void'(rec_buf.pop_back());
    end
    if (want[FltLong]) repeat ($urandom_range(1, 12)) rec_buf.push_back(8'($urandom));
  endtask

  // enter and leave at a falling edge; tvalid stays high between back-to-back transactions
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_buf.size(); i++) send_byte(rec_buf[i], i == rec_buf.size() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    #15ms;
    $display("** session_record_validator_unit: FAILED **");
    $finish;
  end

  initial begin
    fault_e fa;
    fault_e fb;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // a clean record, one with up to two random faults, and a lone marked byte
    build_record(FltNone, FltNone);
    send_record();
    fa = fault_e'($urandom_range(1, FltCount - 1));
    fb = fault_e'($urandom_range(1, FltCount - 1));
    build_record(fa, fb);
    send_record();
    rec_buf.delete();
    rec_buf.push_back(8'hff);
    send_record();
    wait_drained();

    // short runs of noise make up the rest
    for (int n = 0; sent < ItemTarget; n++) begin
      steady = ($urandom_range(0, 3) == 0);
      build_noise($urandom_range(1, 24));
      send_record();
      if (n % 8 == 7) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** session_record_validator_unit: PASSED **");
    end else begin
      $display("** session_record_validator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/srv_pkg.sv
rtl/core/session_record_validator_unit.sv
bench/record_board_pkg.sv
bench/tb_top.sv
